// ===== rtl/core/brf_pkg.sv =====
// shared types and constants for the byte ring fifo with peek
package brf_pkg;

    localparam int BYTE_W        = 8;
    localparam int SLOT_W        = 9;
    localparam int PTR_W         = 8;
    localparam int DEPTH_DEFAULT = 256;
    localparam int RING_MAX      = 256;
    localparam logic [SLOT_W-1:0] SLOTS_RESET = 9'd256;
    localparam logic [SLOT_W-1:0] SLOTS_MIN   = 9'd2;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data_in;
        logic [BYTE_W-1:0] peek_offset;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] data_out;
        logic [BYTE_W-1:0] fill_count;
        logic [BYTE_W-1:0] free_space;
    } rsp_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slots_in_use;
    } cfg_t;

endpackage

// ===== rtl/core/brf_chan_if.sv =====
// valid/ready channel carrying one word of a given payload type
interface brf_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/byte_ring_fifo_with_peek.sv =====
// byte ring fifo with put, get, peek and clear over one ring memory
// Each request word carries one operation (put, get, peek or clear) and produces exactly one
// response word in the cycle after it is accepted, holding the success flag, the byte read, and
// the fill count and free space after the operation. The ring memory has a registered read
// port, so the byte for get and peek arrives with the response in the following cycle, while
// the pointers are updated at the accepting edge. A new request is taken every cycle as long
// as the response register is empty or is being drained in the same cycle, giving one word
// per cycle; a stalled response holds back further requests. The number of ring slots comes
// from the configuration register (clamped to 2 .. min(DEPTH, 256)), capacity is one less,
// and every configuration write empties the fifo. Configure only while no response is pending.
module byte_ring_fifo_with_peek #(
    parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    brf_chan_if.sink   req,
    brf_chan_if.source rsp,
    brf_chan_if.sink   cfg
);

    localparam int RING_N = (DEPTH < brf_pkg::RING_MAX) ? DEPTH : brf_pkg::RING_MAX;
    localparam int AW     = $clog2(RING_N);
    localparam logic [brf_pkg::SLOT_W-1:0] SLOTS_LIM = brf_pkg::SLOT_W'(RING_N);

    brf_pkg::req_t req_word;
    brf_pkg::cfg_t cfg_word;

    logic [brf_pkg::SLOT_W-1:0] slots_reg;
    logic [brf_pkg::SLOT_W-1:0] slots_next;
    logic [brf_pkg::PTR_W-1:0]  rp_reg, rp_next;
    logic [brf_pkg::PTR_W-1:0]  wp_reg, wp_next;

    logic                       rsp_valid_reg;
    logic                       ok_reg;
    logic                       hit_reg;
    logic [brf_pkg::BYTE_W-1:0] fill_reg;
    logic [brf_pkg::BYTE_W-1:0] free_reg;
    logic [brf_pkg::BYTE_W-1:0] rdata_reg;

    logic [brf_pkg::BYTE_W-1:0] mem [RING_N];

    logic                       in_acc;
    logic                       cfg_acc;
    logic [brf_pkg::SLOT_W-1:0] s_eff;
    logic [brf_pkg::SLOT_W-1:0] cnt;
    logic [brf_pkg::SLOT_W-1:0] cnt_next;
    logic                       not_full;
    logic                       not_empty;
    logic                       peek_hit;
    logic [brf_pkg::SLOT_W-1:0] rp_inc, wp_inc;
    logic [brf_pkg::SLOT_W-1:0] peek_sum;
    logic [brf_pkg::SLOT_W-1:0] peek_addr;
    logic                       ok_c;
    logic                       rd_en;
    logic                       wr_en;
    logic [AW-1:0]              raddr;
    logic [AW-1:0]              waddr;

    assign req_word = req.data;
    assign cfg_word = cfg.data;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;
    assign in_acc    = req.valid && req.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;

    // effective slot count
    always_comb
    begin
        priority if (slots_reg < brf_pkg::SLOTS_MIN)
        begin
            s_eff = brf_pkg::SLOTS_MIN;
        end
        else if (slots_reg > SLOTS_LIM)
        begin
            s_eff = SLOTS_LIM;
        end
        else
        begin
            s_eff = slots_reg;
        end
    end

    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            cnt = {1'b0, wp_reg} - {1'b0, rp_reg};
        end
        else
        begin
            cnt = {1'b0, wp_reg} + s_eff - {1'b0, rp_reg};
        end
    end

    assign not_full  = cnt < (s_eff - 9'd1);
    assign not_empty = cnt != '0;
    assign peek_hit  = {1'b0, req_word.peek_offset} < cnt;

    assign rp_inc   = {1'b0, rp_reg} + 9'd1;
    assign wp_inc   = {1'b0, wp_reg} + 9'd1;
    assign peek_sum = {1'b0, rp_reg} + {1'b0, req_word.peek_offset};
    assign peek_addr = (peek_sum >= s_eff) ? (peek_sum - s_eff) : peek_sum;

    always_comb
    begin
        rp_next  = rp_reg;
        wp_next  = wp_reg;
        cnt_next = cnt;
        ok_c     = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        raddr    = rp_reg[AW-1:0];
        unique case (req_word.op)
            brf_pkg::OP_PUT:
            begin
                if (not_full)
                begin
                    ok_c     = 1'b1;
                    wr_en    = in_acc;
                    wp_next  = (wp_inc == s_eff) ? '0 : wp_inc[brf_pkg::PTR_W-1:0];
                    cnt_next = cnt + 9'd1;
                end
            end
            brf_pkg::OP_GET:
            begin
                if (not_empty)
                begin
                    ok_c     = 1'b1;
                    rd_en    = in_acc;
                    rp_next  = (rp_inc == s_eff) ? '0 : rp_inc[brf_pkg::PTR_W-1:0];
                    cnt_next = cnt - 9'd1;
                end
            end
            brf_pkg::OP_PEEK:
            begin
                raddr = peek_addr[AW-1:0];
                if (peek_hit)
                begin
                    ok_c  = 1'b1;
                    rd_en = in_acc;
                end
            end
            brf_pkg::OP_CLEAR:
            begin
                ok_c     = 1'b1;
                rp_next  = wp_reg;
                cnt_next = '0;
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase
    end

    assign waddr = wp_reg[AW-1:0];

    always_comb
    begin
        slots_next = slots_reg;
        if (cfg_acc)
        begin
            slots_next = cfg_word.slots_in_use;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg     <= brf_pkg::SLOTS_RESET;
            rp_reg        <= '0;
            wp_reg        <= '0;
            rsp_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            slots_reg <= slots_next;
            if (cfg_acc)
            begin
                rp_reg <= '0;
                wp_reg <= '0;
            end
            else if (in_acc)
            begin
                rp_reg <= rp_next;
                wp_reg <= wp_next;
            end
            if (in_acc)
            begin
                rsp_valid_reg <= 1'b1;
                ok_reg        <= ok_c;
                hit_reg       <= rd_en;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // response counts, payload only
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            fill_reg <= cnt_next[brf_pkg::BYTE_W-1:0];
            free_reg <= 8'((s_eff - 9'd1) - cnt_next);
        end
    end

    // ring memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= req_word.data_in;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.data.ok         = ok_reg;
    assign rsp.data.data_out   = hit_reg ? rdata_reg : '0;
    assign rsp.data.fill_count = fill_reg;
    assign rsp.data.free_space = free_reg;

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> rsp_valid_reg)
        else $error("accepted request produced no response");

    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (rp_reg < s_eff) && (wp_reg < s_eff))
        else $error("pointer outside the ring");

    a_full_put_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !cfg_acc && req_word.op == brf_pkg::OP_PUT && !not_full)
        |=> $stable(wp_reg))
        else $error("put into full ring moved write pointer");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !ok_reg) |-> (rsp.data.data_out == '0))
        else $error("failed operation returned data");

endmodule
